// ----- rtl/core/wbs_pkg.sv -----
`default_nettype none

package wbs_pkg;

  // Default dimensions
  localparam int MAX_WORDS_DEF    = 64;
  localparam int MAX_WORD_LEN_DEF = 16;

  // Field widths
  localparam int SYMBOL_W = 8;
  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 2;

  // Widest word index and length that the parameter ranges allow
  localparam int WORD_IDX_MAX_W = 10;
  localparam int LEN_MAX_W      = 5;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DICT  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TEXT  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LONG = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Dictionary write command
  typedef struct packed {
    logic                      char_en;
    logic                      len_en;
    logic [WORD_IDX_MAX_W-1:0] word;
    logic [LEN_MAX_W-1:0]      lane;
    logic [SYMBOL_W-1:0]       symbol;
    logic [LEN_MAX_W-1:0]      length;
  } wbs_wr_t;

endpackage

`default_nettype wire

// ----- rtl/core/wbs_item_if.sv -----
`default_nettype none

interface wbs_item_if;
  logic                          valid;
  logic                          ready;
  logic [wbs_pkg::OPCODE_W-1:0]  opcode;
  logic [wbs_pkg::SYMBOL_W-1:0]  symbol;
  logic                          last;

  modport source (output valid, output opcode, output symbol, output last, input ready);
  modport sink   (input valid, input opcode, input symbol, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wbs_result_if.sv -----
`default_nettype none

interface wbs_result_if;
  logic                          valid;
  logic                          ready;
  logic                          prefix_ok;
  logic                          end_of_text;
  logic [wbs_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output prefix_ok, output end_of_text, output status,
                  input ready);
  modport sink   (input valid, input prefix_ok, input end_of_text, input status,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wbs_dict.sv -----
`default_nettype none

// Dictionary storage and the shared word compare unit.
// One stored word is read per cycle; its characters are checked against
// the text window and its length against the reach bits.
module wbs_dict #(
  parameter int MAX_WORDS    = wbs_pkg::MAX_WORDS_DEF,
  parameter int MAX_WORD_LEN = wbs_pkg::MAX_WORD_LEN_DEF
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire wbs_pkg::wbs_wr_t                              wr,
  input  wire logic                                          rd_en,
  input  wire logic [(MAX_WORDS > 1 ? $clog2(MAX_WORDS) : 1)-1:0] rd_addr,
  input  wire logic [MAX_WORD_LEN-1:0][wbs_pkg::SYMBOL_W-1:0] window,
  input  wire logic [MAX_WORD_LEN:0]                         reach,
  output logic                                               cmp_valid,
  output logic                                               hit
);

  localparam int AW    = MAX_WORDS > 1 ? $clog2(MAX_WORDS) : 1;
  localparam int LENW  = $clog2(MAX_WORD_LEN + 1);
  localparam int LANEW = MAX_WORD_LEN > 1 ? $clog2(MAX_WORD_LEN) : 1;

  logic [MAX_WORD_LEN-1:0][wbs_pkg::SYMBOL_W-1:0] dict_mem [MAX_WORDS];
  logic [LENW-1:0]                                len_mem  [MAX_WORDS];

  logic [MAX_WORD_LEN-1:0][wbs_pkg::SYMBOL_W-1:0] rd_row;
  logic [LENW-1:0]                                rd_len;
  logic                                           match;
  logic                                           len_ok;

  // Memories: byte-lane character writes, length write, registered reads
  always_ff @(posedge clk) begin
    if (wr.char_en) begin
      dict_mem[wr.word[AW-1:0]][wr.lane[LANEW-1:0]] <= wr.symbol;
    end
    if (wr.len_en) begin
      len_mem[wr.word[AW-1:0]] <= wr.length[LENW-1:0];
    end
    rd_row <= dict_mem[rd_addr];
    rd_len <= len_mem[rd_addr];
  end

  // Read data is valid in the cycle after the read is requested
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= rd_en;
    end
  end

  // Character c of the word lines up with window entry len-1-c
  always_comb begin
    logic [LENW-1:0] idx;
    match = 1'b1;
    idx   = '0;
    for (int c = 0; c < MAX_WORD_LEN; c++) begin
      if (LENW'(c) < rd_len) begin
        idx = rd_len - LENW'(c) - LENW'(1);
        if (rd_row[c] != window[idx[LANEW-1:0]]) begin
          match = 1'b0;
        end
      end
    end
  end

  assign len_ok = (rd_len != '0) && (rd_len <= LENW'(MAX_WORD_LEN));
  assign hit    = cmp_valid && len_ok && reach[rd_len] && match;

endmodule

`default_nettype wire

// ----- rtl/core/word_break_segmentation_unit.sv -----
`default_nettype none

// Word-break segmentation. Dictionary characters (one per transfer, last
// closes a word) are written to the dictionary while it has room; a closing
// character also returns a status result. Each text character returns
// whether the text prefix so far splits into stored words: the dictionary
// memory is scanned one word per cycle through its single read port, and
// the scan stops early when a matching word is found. A result waiting in
// the output register does not stop the next transfer from being taken.
module word_break_segmentation_unit #(
  parameter int MAX_WORDS    = wbs_pkg::MAX_WORDS_DEF,
  parameter int MAX_WORD_LEN = wbs_pkg::MAX_WORD_LEN_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  wbs_item_if.sink          item,
  wbs_result_if.source      result
);

  localparam int AW    = MAX_WORDS > 1 ? $clog2(MAX_WORDS) : 1;
  localparam int CW    = $clog2(MAX_WORDS + 1);
  localparam int LENW  = $clog2(MAX_WORD_LEN + 1);
  localparam int LANEW = MAX_WORD_LEN > 1 ? $clog2(MAX_WORD_LEN) : 1;
  localparam int WINW  = MAX_WORD_LEN * wbs_pkg::SYMBOL_W;

  wbs_pkg::state_t state;

  logic [CW-1:0]                   word_count;
  logic [LENW-1:0]                 load_length;
  logic [wbs_pkg::STATUS_W-1:0]    load_error;
  logic [MAX_WORD_LEN-1:0][wbs_pkg::SYMBOL_W-1:0] window;
  logic [MAX_WORD_LEN:0]           reach;
  logic [CW-1:0]                   scan_idx;
  logic                            text_last;

  // Result waiting to enter the output register
  logic                            pend_ok;
  logic                            pend_eot;
  logic [wbs_pkg::STATUS_W-1:0]    pend_status;

  logic                            accept;
  logic                            rd_en;
  logic                            cmp_valid;
  logic                            hit;
  logic                            scan_done;
  logic                            emit_go;
  logic [LENW-1:0]                 load_length_next;
  logic [wbs_pkg::STATUS_W-1:0]    load_error_next;
  logic                            char_store;
  wbs_pkg::wbs_wr_t                wr;

  assign item.ready = (state == wbs_pkg::ST_IDLE);
  assign accept     = item.valid && item.ready;

  // Dictionary load bookkeeping for a character transfer
  always_comb begin
    load_length_next = load_length;
    load_error_next  = load_error;
    char_store       = 1'b0;
    if (load_error == wbs_pkg::STATUS_OK) begin
      if (word_count >= CW'(MAX_WORDS)) begin
        load_error_next = wbs_pkg::STATUS_FULL;
      end else if (load_length >= LENW'(MAX_WORD_LEN)) begin
        load_error_next = wbs_pkg::STATUS_LONG;
      end else begin
        char_store       = 1'b1;
        load_length_next = load_length + LENW'(1);
      end
    end
  end

  // Write command to the dictionary
  always_comb begin
    wr         = '0;
    wr.word    = wbs_pkg::WORD_IDX_MAX_W'(word_count[AW-1:0]);
    wr.lane    = wbs_pkg::LEN_MAX_W'(load_length[LANEW-1:0]);
    wr.symbol  = item.symbol;
    wr.length  = wbs_pkg::LEN_MAX_W'(load_length_next);
    if (accept && item.opcode == wbs_pkg::OP_DICT) begin
      wr.char_en = char_store;
      wr.len_en  = item.last && (load_error_next == wbs_pkg::STATUS_OK);
    end
  end

  // Scan control: one word read per cycle until a hit or the list ends
  assign scan_done = (state == wbs_pkg::ST_SCAN) &&
                     (hit || (!cmp_valid && scan_idx >= word_count));
  assign rd_en     = (state == wbs_pkg::ST_SCAN) && !scan_done && (scan_idx < word_count);
  assign emit_go   = (state == wbs_pkg::ST_EMIT) && (!result.valid || result.ready);

  wbs_dict #(
    .MAX_WORDS    (MAX_WORDS),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_dict (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .rd_en     (rd_en),
    .rd_addr   (scan_idx[AW-1:0]),
    .window    (window),
    .reach     (reach),
    .cmp_valid (cmp_valid),
    .hit       (hit)
  );

  // Sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= wbs_pkg::ST_IDLE;
      word_count  <= '0;
      load_length <= '0;
      load_error  <= wbs_pkg::STATUS_OK;
      window      <= '0;
      reach       <= (MAX_WORD_LEN + 1)'(1);
      scan_idx    <= '0;
    end else begin
      unique case (state)
        wbs_pkg::ST_IDLE: begin
          if (accept) begin
            unique case (item.opcode)
              wbs_pkg::OP_CLEAR: begin
                word_count  <= '0;
                load_length <= '0;
                load_error  <= wbs_pkg::STATUS_OK;
              end
              wbs_pkg::OP_DICT: begin
                if (item.last) begin
                  if (load_error_next == wbs_pkg::STATUS_OK) begin
                    word_count <= word_count + CW'(1);
                  end
                  load_length <= '0;
                  load_error  <= wbs_pkg::STATUS_OK;
                  state       <= wbs_pkg::ST_EMIT;
                end else begin
                  load_length <= load_length_next;
                  load_error  <= load_error_next;
                end
              end
              wbs_pkg::OP_TEXT: begin
                window   <= WINW'({window, item.symbol});
                reach    <= (MAX_WORD_LEN + 1)'({reach, 1'b0});
                scan_idx <= '0;
                state    <= wbs_pkg::ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        wbs_pkg::ST_SCAN: begin
          if (rd_en) begin
            scan_idx <= scan_idx + CW'(1);
          end
          if (scan_done) begin
            if (text_last) begin
              window <= '0;
              reach  <= (MAX_WORD_LEN + 1)'(1);
            end else begin
              reach[0] <= hit;
            end
            state <= wbs_pkg::ST_EMIT;
          end
        end
        wbs_pkg::ST_EMIT: begin
          if (emit_go) begin
            state <= wbs_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= wbs_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Pending result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      text_last   <= item.last;
      pend_ok     <= 1'b0;
      pend_eot    <= 1'b0;
      pend_status <= load_error_next;
    end
    if (scan_done) begin
      pend_ok     <= hit;
      pend_eot    <= text_last;
      pend_status <= wbs_pkg::STATUS_OK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit_go) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      result.prefix_ok   <= pend_ok;
      result.end_of_text <= pend_eot;
      result.status      <= pend_status;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    word_count <= CW'(MAX_WORDS))
    else $error("word count beyond capacity");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    load_length <= LENW'(MAX_WORD_LEN))
    else $error("load length beyond word limit");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == wbs_pkg::ST_SCAN) |-> (scan_idx <= word_count))
    else $error("scan index passed word count");

  a_hit_in_scan: assert property (@(posedge clk) disable iff (rst)
    hit |-> (state == wbs_pkg::ST_SCAN))
    else $error("compare hit outside scan");

  a_reach_open: assert property (@(posedge clk) disable iff (rst)
    (state == wbs_pkg::ST_SCAN) |-> !reach[0])
    else $error("reach bit zero set during scan");

endmodule

`default_nettype wire
